// File: rtl/next_subset_enumerator_assert.svh
// Assertion macros used by the port-level checker of the subset enumerator.
// Depends on a clock named aclk and an active-low reset named aresetn in scope.
`ifndef NEXT_SUBSET_ENUMERATOR_ASSERT_SVH
`define NEXT_SUBSET_ENUMERATOR_ASSERT_SVH

// A property that is checked only while the block is out of reset.
`define NSE_ASSERT(lbl, prop, msg) \
    lbl: assert property (@(posedge aclk) disable iff (!aresetn) prop) else $error(msg);

// A property that is also checked while reset is applied.
`define NSE_ASSERT_RST(lbl, prop, msg) \
    lbl: assert property (@(posedge aclk) prop) else $error(msg);

`endif

// File: rtl/nse_pkg.sv
// Shared widths, pipeline payload types and bit-vector helpers of the subset enumerator.
// No dependencies.
package nse_pkg;

    localparam int DATA_W   = 32;
    localparam int CNT_W    = 6;
    localparam int SHIFT_W  = 5;
    localparam int MAX_SIZE = 32;

    localparam logic [CNT_W-1:0] SET_SIZE_RST = CNT_W'(MAX_SIZE);

    // Subset left-aligned so that the top used bit sits at the top of the word.
    typedef struct packed {
        logic [DATA_W-1:0] w;
        logic [CNT_W-1:0]  n;
        logic              zero;
    } s1_t;

    typedef struct packed {
        logic [DATA_W-1:0] y;
        logic [DATA_W-1:0] run;
        logic [CNT_W-1:0]  n;
        logic              zero;
    } s2_t;

    typedef struct packed {
        logic [DATA_W-1:0] y;
        logic [DATA_W-1:0] h;
        logic [CNT_W-1:0]  t;
        logic [CNT_W-1:0]  n;
        logic              zero;
        logic              found;
    } s3_t;

    typedef struct packed {
        logic [DATA_W-1:0] ra;
        logic [DATA_W-1:0] nf;
        logic [CNT_W-1:0]  n;
        logic              zero;
        logic              found;
    } s4_t;

    // Every bit at or below the highest set bit becomes one.
    function automatic logic [DATA_W-1:0] smear_down(input logic [DATA_W-1:0] x);
        logic [DATA_W-1:0] s;
        s = x;
        s = s | (s >> 1);
        s = s | (s >> 2);
        s = s | (s >> 4);
        s = s | (s >> 8);
        s = s | (s >> 16);
        return s;
    endfunction

    function automatic logic [CNT_W-1:0] pop32(input logic [DATA_W-1:0] x);
        logic [1:0] a [16];
        logic [2:0] b [8];
        logic [3:0] c [4];
        logic [4:0] d [2];
        for (int i = 0; i < 16; i++) a[i] = {1'b0, x[2*i]} + {1'b0, x[2*i+1]};
        for (int i = 0; i < 8; i++)  b[i] = {1'b0, a[2*i]} + {1'b0, a[2*i+1]};
        for (int i = 0; i < 4; i++)  c[i] = {1'b0, b[2*i]} + {1'b0, b[2*i+1]};
        for (int i = 0; i < 2; i++)  d[i] = {1'b0, c[2*i]} + {1'b0, c[2*i+1]};
        return {1'b0, d[0]} + {1'b0, d[1]};
    endfunction

endpackage

// File: rtl/nse_align.sv
// First pipeline stage: clamps the width in use and left-aligns the subset.
// Depends on nse_pkg.
module nse_align import nse_pkg::*; (
    input  logic              aclk,
    input  logic              aresetn,
    input  logic [CNT_W-1:0]  set_size,
    input  logic              in_valid,
    output logic              in_ready,
    input  logic [DATA_W-1:0] in_set,
    output logic              out_valid,
    input  logic              out_ready,
    output s1_t               out_data
);

    logic             vld_reg;
    s1_t              data_reg;
    s1_t              data_next;
    logic [CNT_W-1:0] n;
    logic [CNT_W-1:0] sh;

    assign in_ready = !vld_reg || out_ready;

    always_comb begin
        n  = (set_size > CNT_W'(MAX_SIZE)) ? CNT_W'(MAX_SIZE) : set_size;
        sh = CNT_W'(DATA_W) - n;
        data_next.n    = n;
        data_next.zero = (n == '0);
        // Shifting up by the unused width also drops every bit above the width.
        data_next.w    = data_next.zero ? '0 : (in_set << sh[SHIFT_W-1:0]);
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            vld_reg <= 1'b0;
        end else if (in_ready) begin
            vld_reg <= in_valid;
        end
    end

    always_ff @(posedge aclk) begin
        if (in_ready && in_valid) begin
            data_reg <= data_next;
        end
    end

    assign out_valid = vld_reg;
    assign out_data  = data_reg;

endmodule

// File: rtl/nse_scan.sv
// Second and third pipeline stages: strip the top run of ones, then isolate the
// highest remaining one and count the run. Depends on nse_pkg.
module nse_scan import nse_pkg::*; (
    input  logic aclk,
    input  logic aresetn,
    input  logic in_valid,
    output logic in_ready,
    input  s1_t  in_data,
    output logic out_valid,
    input  logic out_ready,
    output s3_t  out_data
);

    logic vld2_reg;
    s2_t  data2_reg;
    s2_t  data2_next;
    logic ready2;
    logic vld3_reg;
    s3_t  data3_reg;
    s3_t  data3_next;
    logic ready3;
    logic [DATA_W-1:0] below;

    assign ready3   = !vld3_reg || out_ready;
    assign ready2   = !vld2_reg || ready3;
    assign in_ready = ready2;

    always_comb begin
        // Everything at or below the highest zero; the rest is the top run.
        below           = smear_down(~in_data.w);
        data2_next.y    = in_data.w & below;
        data2_next.run  = ~below;
        data2_next.n    = in_data.n;
        data2_next.zero = in_data.zero;
    end

    always_comb begin
        data3_next.y     = data2_reg.y;
        data3_next.h     = data2_reg.y & ~(smear_down(data2_reg.y) >> 1);
        data3_next.t     = pop32(data2_reg.run);
        data3_next.n     = data2_reg.n;
        data3_next.zero  = data2_reg.zero;
        data3_next.found = |data2_reg.y;
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            vld2_reg <= 1'b0;
            vld3_reg <= 1'b0;
        end else begin
            if (ready2) begin
                vld2_reg <= in_valid;
            end
            if (ready3) begin
                vld3_reg <= vld2_reg;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (ready2 && in_valid) begin
            data2_reg <= data2_next;
        end
        if (ready3 && vld2_reg) begin
            data3_reg <= data3_next;
        end
    end

    assign out_valid = vld3_reg;
    assign out_data  = data3_reg;

endmodule

// File: rtl/nse_form.sv
// Fourth and fifth pipeline stages: build the next subset in aligned form, then
// shift it back down and pick the case. Depends on nse_pkg.
module nse_form import nse_pkg::*; (
    input  logic              aclk,
    input  logic              aresetn,
    input  logic              in_valid,
    output logic              in_ready,
    input  s3_t               in_data,
    output logic              out_valid,
    input  logic              out_ready,
    output logic [DATA_W-1:0] out_set
);

    logic              vld4_reg;
    s4_t               data4_reg;
    s4_t               data4_next;
    logic              ready4;
    logic              vld5_reg;
    logic [DATA_W-1:0] set5_reg;
    logic [DATA_W-1:0] set5_next;
    logic              ready5;
    logic [CNT_W:0]    amt;
    logic [DATA_W:0]   hi;
    logic [DATA_W:0]   lo;
    logic [DATA_W:0]   blk;
    logic [CNT_W:0]    t1;
    logic [CNT_W-1:0]  k;
    logic [CNT_W-1:0]  sh;

    assign ready5   = !vld5_reg || out_ready;
    assign ready4   = !vld4_reg || ready5;
    assign in_ready = ready4;

    always_comb begin
        // The one at h is cleared and t+1 ones are laid just above it.
        amt = {1'b0, in_data.t} + (CNT_W+1)'(2);
        hi  = {1'b0, in_data.h} << amt;
        lo  = {in_data.h, 1'b0};
        blk = hi - lo;
        data4_next.ra = (in_data.y & (in_data.h - DATA_W'(1))) | blk[DATA_W-1:0];
        // With no one below the top run, the next size starts at the bottom.
        t1  = {1'b0, in_data.t} + (CNT_W+1)'(1);
        k   = (t1 > {1'b0, in_data.n}) ? in_data.n : t1[CNT_W-1:0];
        data4_next.nf    = (k == CNT_W'(DATA_W)) ? '1
                                                 : ((DATA_W'(1) << k[SHIFT_W-1:0]) - DATA_W'(1));
        data4_next.n     = in_data.n;
        data4_next.zero  = in_data.zero;
        data4_next.found = in_data.found;
    end

    always_comb begin
        sh = CNT_W'(DATA_W) - data4_reg.n;
        priority if (data4_reg.zero) begin
            set5_next = '0;
        end else if (data4_reg.found) begin
            set5_next = data4_reg.ra >> sh[SHIFT_W-1:0];
        end else begin
            set5_next = data4_reg.nf;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            vld4_reg <= 1'b0;
            vld5_reg <= 1'b0;
        end else begin
            if (ready4) begin
                vld4_reg <= in_valid;
            end
            if (ready5) begin
                vld5_reg <= vld4_reg;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (ready4 && in_valid) begin
            data4_reg <= data4_next;
        end
        if (ready5 && vld4_reg) begin
            set5_reg <= set5_next;
        end
    end

    assign out_valid = vld5_reg;
    assign out_set   = set5_reg;

endmodule

// File: rtl/nse_count.sv
// Last pipeline stage: counts the ones of the next subset into the output register.
// Depends on nse_pkg.
module nse_count import nse_pkg::*; (
    input  logic              aclk,
    input  logic              aresetn,
    input  logic              in_valid,
    output logic              in_ready,
    input  logic [DATA_W-1:0] in_set,
    output logic              m_valid,
    input  logic              m_ready,
    output logic [DATA_W-1:0] m_next_set,
    output logic [CNT_W-1:0]  m_ones_count
);

    logic              vld_reg;
    logic [DATA_W-1:0] set_reg;
    logic [CNT_W-1:0]  cnt_reg;

    assign in_ready = !vld_reg || m_ready;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            vld_reg <= 1'b0;
        end else if (in_ready) begin
            vld_reg <= in_valid;
        end
    end

    always_ff @(posedge aclk) begin
        if (in_ready && in_valid) begin
            set_reg <= in_set;
            cnt_reg <= pop32(in_set);
        end
    end

    assign m_valid      = vld_reg;
    assign m_next_set   = set_reg;
    assign m_ones_count = cnt_reg;

endmodule

// File: rtl/next_subset_enumerator.sv
// Subset enumerator: each item on the s_ side is a subset of the low set_size
// elements, and the matching m_ item is the subset that follows it in size-major
// order together with its count of ones. The block is a six-stage pipeline that
// takes one item every cycle while the m_ side does not stall; each stage holds
// its item until the next stage frees, so a stall fills the gaps before it stops
// the input. set_size is written through cfg_wr_en and cfg_wr_data and is read
// as an item enters, so it should only change while no item is in flight.
module next_subset_enumerator import nse_pkg::*; (
    input  logic              aclk,
    input  logic              aresetn,
    input  logic              cfg_wr_en,
    input  logic [CNT_W-1:0]  cfg_wr_data,
    input  logic              s_valid,
    output logic              s_ready,
    input  logic [DATA_W-1:0] s_current_set,
    output logic              m_valid,
    input  logic              m_ready,
    output logic [DATA_W-1:0] m_next_set,
    output logic [CNT_W-1:0]  m_ones_count
);

    logic [CNT_W-1:0]  set_size_reg;
    logic              a_valid;
    logic              a_ready;
    s1_t               a_data;
    logic              b_valid;
    logic              b_ready;
    s3_t               b_data;
    logic              c_valid;
    logic              c_ready;
    logic [DATA_W-1:0] c_set;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            set_size_reg <= SET_SIZE_RST;
        end else if (cfg_wr_en) begin
            set_size_reg <= cfg_wr_data;
        end
    end

    nse_align u_align (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .set_size  (set_size_reg),
        .in_valid  (s_valid),
        .in_ready  (s_ready),
        .in_set    (s_current_set),
        .out_valid (a_valid),
        .out_ready (a_ready),
        .out_data  (a_data)
    );

    nse_scan u_scan (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .in_valid  (a_valid),
        .in_ready  (a_ready),
        .in_data   (a_data),
        .out_valid (b_valid),
        .out_ready (b_ready),
        .out_data  (b_data)
    );

    nse_form u_form (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .in_valid  (b_valid),
        .in_ready  (b_ready),
        .in_data   (b_data),
        .out_valid (c_valid),
        .out_ready (c_ready),
        .out_set   (c_set)
    );

    nse_count u_count (
        .aclk         (aclk),
        .aresetn      (aresetn),
        .in_valid     (c_valid),
        .in_ready     (c_ready),
        .in_set       (c_set),
        .m_valid      (m_valid),
        .m_ready      (m_ready),
        .m_next_set   (m_next_set),
        .m_ones_count (m_ones_count)
    );

endmodule

// File: rtl/nse_checker.sv
// Port-level checker of the subset enumerator, bound to the top level.
// Depends on nse_pkg and next_subset_enumerator_assert.svh.
`include "next_subset_enumerator_assert.svh"

module nse_checker import nse_pkg::*; (
    input logic              aclk,
    input logic              aresetn,
    input logic              s_ready,
    input logic              m_valid,
    input logic              m_ready,
    input logic [DATA_W-1:0] m_next_set,
    input logic [CNT_W-1:0]  m_ones_count
);

    // A result that is waiting must stay as it is.
    `NSE_ASSERT(a_out_hold, m_valid && !m_ready |=> m_valid && $stable(m_next_set) && $stable(m_ones_count), "result item changed while stalled")

    // The count must agree with the subset it travels with.
    `NSE_ASSERT(a_count_match, m_valid |-> m_ones_count == CNT_W'($countones(m_next_set)), "ones_count does not match next_set")

    // With the output free, nothing upstream may hold back a new item.
    `NSE_ASSERT(a_ready_free, !m_valid || m_ready |-> s_ready, "input stalled although output is free")

    // Reset must empty the pipeline.
    `NSE_ASSERT_RST(a_reset_empty, !aresetn |=> !m_valid, "result item present after reset")

endmodule

bind next_subset_enumerator nse_checker u_nse_checker (
    .aclk         (aclk),
    .aresetn      (aresetn),
    .s_ready      (s_ready),
    .m_valid      (m_valid),
    .m_ready      (m_ready),
    .m_next_set   (m_next_set),
    .m_ones_count (m_ones_count)
);

// File: tb/next_subset_checker.sv
`timescale 1ns / 100ps
// Checker for the subset enumerator: watches the configuration port and both
// channels, predicts each successor and compares it field by field. Uses nse_pkg.
module next_subset_checker import nse_pkg::*; (
    input  logic              aclk,
    input  logic              aresetn,
    input  logic              cfg_wr_en,
    input  logic [CNT_W-1:0]  cfg_wr_data,
    input  logic              s_valid,
    input  logic              s_ready,
    input  logic [DATA_W-1:0] s_current_set,
    input  logic              m_valid,
    input  logic              m_ready,
    input  logic [DATA_W-1:0] m_next_set,
    input  logic [CNT_W-1:0]  m_ones_count,
    output int                error_count,
    output int                pending_items
);

    typedef struct {
        logic [DATA_W-1:0] next_set;
        logic [CNT_W-1:0]  ones;
    } successor_t;

    successor_t       successor_q[$];
    successor_t       want;
    logic [CNT_W-1:0] width_reg;
    int               mismatches = 0;

    function automatic successor_t successor_of(input logic [CNT_W-1:0] size,
                                                input logic [DATA_W-1:0] cur);
        successor_t r;
        int         n;
        int         t;
        int         p;
        logic [63:0] mask;
        logic [63:0] v;
        logic [63:0] nxt;
        r.next_set = '0;
        r.ones = '0;
        n = (size > MAX_SIZE) ? MAX_SIZE : int'(size);
        if (n == 0) return r;
        mask = (64'd1 << n) - 64'd1;
        v = {32'd0, cur} & mask;
        // Length of the run of ones at the top of the used width.
        t = 0;
        p = n - 1;
        while (p >= 0 && v[p]) begin
            t++;
            p--;
        end
        // Highest one below that run, if any.
        while (p >= 0 && !v[p]) p--;
        if (p < 0) begin
            nxt = (64'd1 << ((t + 1 > n) ? n : t + 1)) - 64'd1;
        end else if (t == 0) begin
            nxt = (v & ~(64'd1 << p)) | (64'd1 << (p + 1));
        end else begin
            nxt = (v & ((64'd1 << p) - 64'd1)) | (((64'd1 << (t + 1)) - 64'd1) << (p + 1));
        end
        nxt &= mask;
        r.next_set = nxt[DATA_W-1:0];
        for (int i = 0; i < DATA_W; i++) r.ones = r.ones + CNT_W'(r.next_set[i]);
        return r;
    endfunction

    always @(posedge aclk) begin
        if (!aresetn) begin
            width_reg <= SET_SIZE_RST;
            successor_q.delete();
        end else begin
            if (cfg_wr_en) width_reg <= cfg_wr_data;
            if (s_valid && s_ready)
                successor_q.insert(successor_q.size(), successor_of(width_reg, s_current_set));
            if (m_valid && m_ready) begin
                if (successor_q.size() == 0) begin
                    $display("%0t: unexpected item, expected none, actual next_set %h ones_count %0d",
                             $time, m_next_set, m_ones_count);
                    mismatches++;
                end else begin
                    want = successor_q.pop_front();
                    if (m_next_set !== want.next_set) begin
                        $display("%0t: next_set mismatch, expected %h, actual %h",
                                 $time, want.next_set, m_next_set);
                        mismatches++;
                    end
                    if (m_ones_count !== want.ones) begin
                        $display("%0t: ones_count mismatch, expected %0d, actual %0d",
                                 $time, want.ones, m_ones_count);
                        mismatches++;
                    end
                end
            end
        end
        error_count <= mismatches;
        pending_items <= successor_q.size();
    end

endmodule

// File: tb/tb_next_subset_enumerator.sv
`timescale 1ns / 100ps
// Top of the subset enumerator testbench: clock, reset, width settings, subset
// stimulus and the verdict. Depends on nse_pkg, the block and next_subset_checker.
module tb_next_subset_enumerator;
    import nse_pkg::*;

    localparam int STALL_LIMIT = 2000;

    logic              aclk = 1'b0;
    logic              aresetn = 1'b0;
    logic              cfg_wr_en = 1'b0;
    logic [CNT_W-1:0]  cfg_wr_data = '0;
    logic              s_valid = 1'b0;
    logic              s_ready;
    logic [DATA_W-1:0] s_current_set = '0;
    logic              m_valid;
    logic              m_ready = 1'b0;
    logic [DATA_W-1:0] m_next_set;
    logic [CNT_W-1:0]  m_ones_count;

    int               error_count;
    int               pending_items;
    int               send_idle_pct = 0;
    int               recv_idle_pct = 0;
    int               stall_cycles = 0;
    logic [CNT_W-1:0] cur_width = SET_SIZE_RST;

    always #6 aclk = ~aclk;

    next_subset_enumerator i_dut (
        .aclk          (aclk),
        .aresetn       (aresetn),
        .cfg_wr_en     (cfg_wr_en),
        .cfg_wr_data   (cfg_wr_data),
        .s_valid       (s_valid),
        .s_ready       (s_ready),
        .s_current_set (s_current_set),
        .m_valid       (m_valid),
        .m_ready       (m_ready),
        .m_next_set    (m_next_set),
        .m_ones_count  (m_ones_count)
    );

    next_subset_checker i_checker (
        .aclk          (aclk),
        .aresetn       (aresetn),
        .cfg_wr_en     (cfg_wr_en),
        .cfg_wr_data   (cfg_wr_data),
        .s_valid       (s_valid),
        .s_ready       (s_ready),
        .s_current_set (s_current_set),
        .m_valid       (m_valid),
        .m_ready       (m_ready),
        .m_next_set    (m_next_set),
        .m_ones_count  (m_ones_count),
        .error_count   (error_count),
        .pending_items (pending_items)
    );

    always @(posedge aclk) begin
        m_ready <= ($urandom_range(99) >= recv_idle_pct);
    end

    always @(posedge aclk) begin
        if ((s_valid && s_ready) || (m_valid && m_ready)) begin
            stall_cycles <= 0;
        end else begin
            stall_cycles <= stall_cycles + 1;
        end
        if (stall_cycles >= STALL_LIMIT) begin
            $display("Testbench completed WITH ERRORS");
            $finish;
        end
    end

    // Lowers valid, waits until every item has come back and lets the pipeline empty.
    task automatic settle();
        s_valid <= 1'b0;
        do @(posedge aclk); while (pending_items != 0);
        repeat (8) @(posedge aclk);
    endtask

    task automatic write_width(input logic [CNT_W-1:0] w);
        settle();
        cfg_wr_en <= 1'b1;
        cfg_wr_data <= w;
        @(posedge aclk);
        cfg_wr_en <= 1'b0;
        cur_width = w;
    endtask

    task automatic send_set(input logic [DATA_W-1:0] x);
        while ($urandom_range(99) < send_idle_pct) begin
            s_valid <= 1'b0;
            @(posedge aclk);
        end
        s_valid <= 1'b1;
        s_current_set <= x;
        do @(posedge aclk); while (!s_ready);
    endtask

    // Subsets shaped around the top run of ones, with junk above the width at times.
    function automatic logic [DATA_W-1:0] random_set(input int w);
        logic [DATA_W-1:0] mask;
        logic [DATA_W-1:0] junk;
        int                t;
        int                k;
        mask = DATA_W'((64'd1 << w) - 64'd1);
        junk = $urandom_range(1) ? ($urandom & ~mask) : '0;
        case ($urandom_range(7))
            0: return $urandom;
            1: return $urandom & mask;
            2, 3: begin
                if (w == 0) return $urandom;
                t = $urandom_range(0, w - 1);
                return junk | (mask & ~(mask >> t)) | ($urandom & (mask >> (t + 1)));
            end
            4: begin
                k = $urandom_range(0, w);
                return junk | DATA_W'((64'd1 << k) - 64'd1);
            end
            5: return junk | ($urandom_range(1) ? mask : '0);
            6: return junk | (mask & (32'd1 << $urandom_range(31)));
            default: begin
                t = $urandom_range(0, w);
                return junk | (mask & ~(mask >> t));
            end
        endcase
    endfunction

    initial begin
        int idle_plan[3][2];
        int extreme_width[3];
        int eff;
        logic [CNT_W-1:0] w;
        idle_plan = '{'{28, 54}, '{54, 28}, '{0, 0}};
        extreme_width = '{1, 63, 0};
        repeat (2) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        // Full width: empty set, full set, top-run and move-up cases.
        write_width(6'd32);
        send_set(32'h0000_0000);
        send_set(32'hFFFF_FFFF);
        send_set(32'h8000_0000);
        send_set(32'h0000_0001);
        send_set(32'h0000_0006);
        send_set(32'hC000_0000);
        send_set(32'hC000_0001);
        send_set(32'h7FFF_FFFF);
        send_set(32'hFFFF_FFFE);
        send_set(32'hAAAA_AAAA);
        send_set(32'h5555_5555);
        // Narrow width: bits above the width must be ignored.
        write_width(6'd5);
        send_set(32'hFFFF_FFE0);
        send_set(32'h0000_001F);
        send_set(32'hFFFF_FFF8);
        write_width(6'd0);
        send_set(32'h1234_5678);
        send_set(32'hFFFF_FFFF);
        // Widths past the maximum saturate.
        write_width(6'd63);
        send_set(32'hFFFF_FFFF);
        send_set(32'h8000_0001);
        write_width(6'd33);
        send_set(32'hE000_0000);
        write_width(6'd1);
        send_set(32'h0000_0000);
        send_set(32'h0000_0001);
        send_set(32'hFFFF_FFFE);

        for (int ph = 0; ph < 3; ph++) begin
            settle();
            send_idle_pct = idle_plan[ph][0];
            recv_idle_pct <= idle_plan[ph][1];
            for (int seg = 0; seg < 5; seg++) begin
                case (seg)
                    0: w = 6'd32;
                    1: w = CNT_W'($urandom_range(1, 32));
                    2: w = CNT_W'($urandom_range(1, 6));
                    3: w = CNT_W'($urandom_range(0, 63));
                    default: w = CNT_W'(extreme_width[ph]);
                endcase
                write_width(w);
                eff = (cur_width > 32) ? 32 : int'(cur_width);
                repeat (43) send_set(random_set(eff));
            end
        end

        settle();
        if (error_count == 0) begin
            $display("Testbench completed without errors");
        end else begin
            $display("Testbench completed WITH ERRORS");
        end
        $finish;
    end

endmodule
